>>> rtl/core/mrtu_pkg.sv
package mrtu_pkg;

  // Receive buffer size; at most one byte less than this is stored per frame.
  localparam int RX_BUFFER_BYTES = 256;
  localparam logic [7:0] RX_LIMIT = 8'(RX_BUFFER_BYTES - 1);

  // Input word kinds, carried on in_tuser.
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_REQUEST = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DEVICE_ROLE      = 3'd0;
  localparam logic [2:0] CFG_OWN_ADDRESS      = 3'd1;
  localparam logic [2:0] CFG_BYTE_GAP_TICKS   = 3'd2;
  localparam logic [2:0] CFG_FRAME_GAP_TICKS  = 3'd3;
  localparam logic [2:0] CFG_RESP_TIMEOUT     = 3'd4;

  // CRC-16 constants, the silence count ceiling, the exception flag and the shortest frame.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] GAP_MAX  = 16'hFFFF;
  localparam logic [7:0]  EXC_FLAG = 8'h80;
  localparam logic [7:0]  MIN_FRAME_BYTES = 8'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ADDRESS   = 3'd1,
    ST_CRC       = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_EXCEPTION = 3'd4,
    ST_FUNCTION  = 3'd5,
    ST_TIMEOUT   = 3'd6,
    ST_SHORT     = 3'd7
  } frame_status_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_RX   = 3'b010,
    PH_WAIT = 3'b100
  } link_phase_t;

  // Everything the end-of-frame check looks at.
  typedef struct packed {
    logic        device_role;
    logic [7:0]  own_address;
    logic [7:0]  sent_address;
    logic [7:0]  sent_function;
    logic [7:0]  first_byte0;
    logic [7:0]  first_byte1;
    logic [7:0]  first_byte2;
    logic [15:0] crc;
    logic [7:0]  byte_count;
    logic        overflow;
  } frame_info_t;

  typedef struct packed {
    frame_status_t status;
    logic [7:0]    exception_code;
  } frame_verdict_t;

  // One byte of the reflected CRC-16, bit by bit.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/modbus_rtu_frame_receiver.sv
// Modbus RTU receive side for a slave or a master. Each input word is a
// received byte, a timer tick or a master request-sent notice, chosen by
// in_tuser; the block takes one word every clock cycle, and the state update,
// the byte-wide CRC-16 step and the gap compares all finish in that cycle.
// A frame ends on the tick at which the silence both exceeds byte_gap_ticks
// and reaches frame_gap_ticks; that tick yields one result word with the
// frame status, the first bytes and the length, and a master that hears
// nothing also gets a timeout word. Results sit in an output register, so a
// new input word is taken in the same cycle that a waiting result leaves;
// only while a result is held and out_tready is low does in_tready drop.
// Configuration writes take effect at once and do not clear frame state.
module modbus_rtu_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // rx_byte, request_address, request_function
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // frame_address, frame_function, exception_code, frame_length
  output logic [2:0]  out_tuser,  // frame_status
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers.
  logic        device_role_r;
  logic [7:0]  own_address_r;
  logic [15:0] byte_gap_r;
  logic [15:0] frame_gap_r;
  logic [15:0] resp_timeout_r;

  // Link state.
  mrtu_pkg::link_phase_t phase_r, phase_nxt;
  logic [15:0] gap_r, gap_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        ovf_r, ovf_nxt;
  logic [7:0]  fb_r   [3];
  logic [7:0]  fb_nxt [3];
  logic [7:0]  sent_addr_r, sent_addr_nxt;
  logic [7:0]  sent_func_r, sent_func_nxt;

  // Output register.
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_data_r;

  logic        in_fire;
  logic        emit;
  logic [2:0]  emit_status;
  logic [31:0] emit_data;
  logic [1:0]  op;
  logic [7:0]  rx_byte;
  logic [15:0] gap_inc;
  logic        gap_end;
  logic        in_rx;
  logic        in_wait;

  mrtu_pkg::frame_info_t    info;
  mrtu_pkg::frame_verdict_t verdict;

  assign op        = in_tuser;
  assign rx_byte   = in_tdata[7:0];
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign in_rx     = (phase_r == mrtu_pkg::PH_RX);
  assign in_wait   = (phase_r == mrtu_pkg::PH_WAIT);

  // Saturating silence count and the frame-end test on it.
  assign gap_inc = (gap_r == mrtu_pkg::GAP_MAX) ? gap_r : gap_r + 16'd1;
  assign gap_end = (gap_inc > byte_gap_r) && (gap_inc >= frame_gap_r);

  // The end-of-frame verdict is always formed from the stored frame.
  assign info.device_role   = device_role_r;
  assign info.own_address   = own_address_r;
  assign info.sent_address  = sent_addr_r;
  assign info.sent_function = sent_func_r;
  assign info.first_byte0   = fb_r[0];
  assign info.first_byte1   = fb_r[1];
  assign info.first_byte2   = fb_r[2];
  assign info.crc           = crc_r;
  assign info.byte_count    = count_r;
  assign info.overflow      = ovf_r;

  mrtu_frame_check u_check (
    .info    (info),
    .verdict (verdict)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_role_r  <= 1'b0;
      own_address_r  <= 8'd1;
      byte_gap_r     <= 16'd19;
      frame_gap_r    <= 16'd33;
      resp_timeout_r <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        mrtu_pkg::CFG_DEVICE_ROLE:     device_role_r  <= cfg_wdata[0];
        mrtu_pkg::CFG_OWN_ADDRESS:     own_address_r  <= cfg_wdata[7:0];
        mrtu_pkg::CFG_BYTE_GAP_TICKS:  byte_gap_r     <= cfg_wdata;
        mrtu_pkg::CFG_FRAME_GAP_TICKS: frame_gap_r    <= cfg_wdata;
        mrtu_pkg::CFG_RESP_TIMEOUT:    resp_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state and result for the accepted word.
  always_comb begin
    logic [15:0] base_crc;
    logic [7:0]  base_count;
    logic        base_ovf;
    logic        base_fb;

    phase_nxt     = phase_r;
    gap_nxt       = gap_r;
    crc_nxt       = crc_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    fb_nxt[0]     = fb_r[0];
    fb_nxt[1]     = fb_r[1];
    fb_nxt[2]     = fb_r[2];
    sent_addr_nxt = sent_addr_r;
    sent_func_nxt = sent_func_r;
    emit          = 1'b0;
    emit_status   = mrtu_pkg::ST_OK;
    emit_data     = 32'h0;

    // A byte outside a running frame starts from a cleared frame.
    base_fb    = !in_rx;
    base_crc   = base_fb ? mrtu_pkg::CRC_INIT : crc_r;
    base_count = base_fb ? 8'd0 : count_r;
    base_ovf   = base_fb ? 1'b0 : ovf_r;

    if (in_fire) begin
      case (op)
        mrtu_pkg::OP_BYTE: begin
          if (in_rx || in_wait || !device_role_r) begin
            phase_nxt = mrtu_pkg::PH_RX;
            gap_nxt   = 16'd0;
            crc_nxt   = base_crc;
            count_nxt = base_count;
            ovf_nxt   = base_ovf;
            if (base_fb) begin
              fb_nxt[0] = 8'h00;
              fb_nxt[1] = 8'h00;
              fb_nxt[2] = 8'h00;
            end
            if (base_count < mrtu_pkg::RX_LIMIT) begin
              if (base_count < 8'd3) begin
                fb_nxt[base_count[1:0]] = rx_byte;
              end
              count_nxt = base_count + 8'd1;
              crc_nxt   = mrtu_pkg::crc16_byte(base_crc, rx_byte);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        mrtu_pkg::OP_TICK: begin
          if (in_rx || in_wait) begin
            gap_nxt = gap_inc;
            if (gap_end && (in_rx || gap_inc >= resp_timeout_r)) begin
              emit = 1'b1;
              if (in_rx) begin
                emit_status = verdict.status;
                emit_data   = {count_r, verdict.exception_code, fb_r[1], fb_r[0]};
              end else begin
                emit_status = mrtu_pkg::ST_TIMEOUT;
              end
              phase_nxt = mrtu_pkg::PH_IDLE;
              gap_nxt   = 16'd0;
              crc_nxt   = mrtu_pkg::CRC_INIT;
              count_nxt = 8'd0;
              ovf_nxt   = 1'b0;
              fb_nxt[0] = 8'h00;
              fb_nxt[1] = 8'h00;
              fb_nxt[2] = 8'h00;
            end
          end
        end
        mrtu_pkg::OP_REQUEST: begin
          if (device_role_r) begin
            sent_addr_nxt = in_tdata[15:8];
            sent_func_nxt = in_tdata[23:16];
            phase_nxt     = mrtu_pkg::PH_WAIT;
            gap_nxt       = 16'd0;
            crc_nxt       = mrtu_pkg::CRC_INIT;
            count_nxt     = 8'd0;
            ovf_nxt       = 1'b0;
            fb_nxt[0]     = 8'h00;
            fb_nxt[1]     = 8'h00;
            fb_nxt[2]     = 8'h00;
          end
        end
        default: ;
      endcase
    end
  end

  // Link state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= mrtu_pkg::PH_IDLE;
      gap_r       <= 16'd0;
      crc_r       <= mrtu_pkg::CRC_INIT;
      count_r     <= 8'd0;
      ovf_r       <= 1'b0;
      fb_r[0]     <= 8'h00;
      fb_r[1]     <= 8'h00;
      fb_r[2]     <= 8'h00;
      sent_addr_r <= 8'h00;
      sent_func_r <= 8'h00;
    end else begin
      phase_r     <= phase_nxt;
      gap_r       <= gap_nxt;
      crc_r       <= crc_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      fb_r[0]     <= fb_nxt[0];
      fb_r[1]     <= fb_nxt[1];
      fb_r[2]     <= fb_nxt[2];
      sent_addr_r <= sent_addr_nxt;
      sent_func_r <= sent_func_nxt;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= emit_status;
      out_data_r   <= emit_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // Only a timer tick can end a frame or a wait.
  a_emit_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (op == mrtu_pkg::OP_TICK))
    else $error("result produced by a word that is not a tick");

  // A result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !emit)
    else $error("result register overwritten while stalled");

  // After a result the receiver is idle with a cleared frame.
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (phase_r == mrtu_pkg::PH_IDLE) && (count_r == 8'd0) && !ovf_r)
    else $error("frame state not cleared after result");

  // An idle link holds no bytes.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == mrtu_pkg::PH_IDLE) |-> (count_r == 8'd0) && (gap_r == 16'd0))
    else $error("idle link holds frame bytes");

  // Overflow is only possible with a full buffer.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == mrtu_pkg::RX_LIMIT))
    else $error("overflow flagged with buffer not full");
`endif

endmodule

>>> rtl/core/mrtu_frame_check.sv
module mrtu_frame_check (
  input  mrtu_pkg::frame_info_t    info,
  output mrtu_pkg::frame_verdict_t verdict
);

  logic [7:0] expect_addr;
  logic [7:0] exc_function;

  assign expect_addr  = info.device_role ? info.sent_address : info.own_address;
  assign exc_function = info.sent_function | mrtu_pkg::EXC_FLAG;

  // Status priority: overflow, short, address, CRC, then the master function check.
  always_comb begin
    verdict.status         = mrtu_pkg::ST_OK;
    verdict.exception_code = 8'h00;
    if (info.overflow) begin
      verdict.status = mrtu_pkg::ST_OVERFLOW;
    end else if (info.byte_count < mrtu_pkg::MIN_FRAME_BYTES) begin
      verdict.status = mrtu_pkg::ST_SHORT;
    end else if (info.first_byte0 != expect_addr) begin
      verdict.status = mrtu_pkg::ST_ADDRESS;
    end else if (info.crc != 16'h0000) begin
      verdict.status = mrtu_pkg::ST_CRC;
    end else if (!info.device_role) begin
      verdict.status = mrtu_pkg::ST_OK;
    end else if (info.first_byte1 == info.sent_function) begin
      verdict.status = mrtu_pkg::ST_OK;
    end else if (info.first_byte1 == exc_function) begin
      verdict.status         = mrtu_pkg::ST_EXCEPTION;
      verdict.exception_code = info.first_byte2;
    end else begin
      verdict.status = mrtu_pkg::ST_FUNCTION;
    end
  end

endmodule

>>> dv/modbus_rtu_frame_receiver_test.sv
module modbus_rtu_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mrtu_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 4;

  // How the two trailing CRC bytes of a frame are formed.
  localparam int CRC_NONE = 0;
  localparam int CRC_GOOD = 1;
  localparam int CRC_BAD  = 2;

  typedef logic [7:0] byte_list_t[$];

  typedef enum logic [1:0] {
    LINK_IDLE,
    LINK_RX,
    LINK_WAIT
  } rx_phase_t;

  typedef struct packed {
    frame_status_t status;
    logic [7:0]    address;
    logic [7:0]    func_code;
    logic [7:0]    exc_code;
    logic [7:0]    length;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // Receiver settings as the model sees them.
  logic        role_master;
  logic [7:0]  own_addr;
  logic [15:0] byte_gap;
  logic [15:0] frame_gap;
  logic [15:0] resp_timeout;

  // Receiver state as the model sees it.
  rx_phase_t   model_phase;
  logic [15:0] silence_ticks;
  logic [15:0] crc_acc;
  logic [7:0]  stored_count;
  logic        overflow_seen;
  logic [7:0]  head_bytes[3];
  logic [7:0]  req_addr;
  logic [7:0]  req_func;

  frame_result_t pending_frames[$];
  int mismatches = 0;
  int words_sent = 0;
  int cycle_count = 0;
  bit idle_enabled = 1'b1;
  int pressure_hold = 0;

  modbus_rtu_frame_receiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Reflected CRC-16, one input bit at a time.
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  task automatic clear_frame_model();
    silence_ticks = '0;
    crc_acc = CRC_INIT;
    stored_count = '0;
    overflow_seen = 1'b0;
    head_bytes[0] = '0;
    head_bytes[1] = '0;
    head_bytes[2] = '0;
  endtask

  task automatic reset_model();
    role_master = 1'b0;
    own_addr = 8'd1;
    byte_gap = 16'd19;
    frame_gap = 16'd33;
    resp_timeout = 16'd1000;
    model_phase = LINK_IDLE;
    req_addr = '0;
    req_func = '0;
    clear_frame_model();
  endtask

  // Status of a frame that has just been closed by silence.
  function automatic frame_result_t judge_frame();
    frame_result_t r;
    logic [7:0] want_addr;
    r.address = head_bytes[0];
    r.func_code = head_bytes[1];
    r.exc_code = '0;
    r.length = stored_count;
    want_addr = role_master ? req_addr : own_addr;
    if (overflow_seen) begin
      r.status = ST_OVERFLOW;
    end else if (stored_count < MIN_FRAME_BYTES) begin
      r.status = ST_SHORT;
    end else if (head_bytes[0] != want_addr) begin
      r.status = ST_ADDRESS;
    end else if (crc_acc != 16'h0000) begin
      r.status = ST_CRC;
    end else if (!role_master || head_bytes[1] == req_func) begin
      r.status = ST_OK;
    end else if (head_bytes[1] == (req_func | EXC_FLAG)) begin
      r.status = ST_EXCEPTION;
      r.exc_code = head_bytes[2];
    end else begin
      r.status = ST_FUNCTION;
    end
    return r;
  endfunction

  // Apply one accepted word to the model and queue any frame report it causes.
  task automatic advance_receiver_model(input logic [1:0] op, input logic [23:0] data);
    frame_result_t r;
    case (op)
      OP_BYTE: begin
        if (model_phase != LINK_IDLE || !role_master) begin
          if (model_phase != LINK_RX) begin
            clear_frame_model();
            model_phase = LINK_RX;
          end
          silence_ticks = '0;
          if (stored_count < RX_LIMIT) begin
            if (stored_count < 8'd3) begin
              head_bytes[stored_count] = data[7:0];
            end
            stored_count = stored_count + 8'd1;
            crc_acc = crc16_step(crc_acc, data[7:0]);
          end else begin
            overflow_seen = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (model_phase != LINK_IDLE) begin
          if (silence_ticks != GAP_MAX) begin
            silence_ticks = silence_ticks + 16'd1;
          end
          if (silence_ticks > byte_gap && silence_ticks >= frame_gap) begin
            if (model_phase == LINK_RX) begin
              pending_frames.push_back(judge_frame());
              model_phase = LINK_IDLE;
              clear_frame_model();
            end else if (silence_ticks >= resp_timeout) begin
              r = '0;
              r.status = ST_TIMEOUT;
              pending_frames.push_back(r);
              model_phase = LINK_IDLE;
              clear_frame_model();
            end
          end
        end
      end
      OP_REQUEST: begin
        if (role_master) begin
          req_addr = data[15:8];
          req_func = data[23:16];
          clear_frame_model();
          model_phase = LINK_WAIT;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    mismatches++;
    $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, want_v, got_v);
  endtask

  // Offer one word, with an occasional gap in front, and wait until it is taken.
  task automatic send_word(input logic [1:0] op, input logic [23:0] data);
    @(negedge clk);
    if (idle_enabled && $urandom_range(0, 9) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = data;
    do @(posedge clk); while (!in_tready);
    advance_receiver_model(op, data);
    words_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(OP_TICK, 24'($urandom));
  endtask

  task automatic send_request(input logic [7:0] addr, input logic [7:0] func);
    send_word(OP_REQUEST, {func, addr, 8'($urandom)});
  endtask

  task automatic send_frame(input byte_list_t body, input int crc_mode);
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (body[i]) begin
      crc = crc16_step(crc, body[i]);
    end
    if (crc_mode == CRC_GOOD) begin
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
    end else if (crc_mode == CRC_BAD) begin
      body.push_back(crc[7:0] ^ 8'($urandom_range(1, 255)));
      body.push_back(crc[15:8]);
    end
    foreach (body[i]) begin
      send_word(OP_BYTE, {16'($urandom), body[i]});
    end
  endtask

  // Ticks of silence needed before the receiver closes a frame or gives up waiting.
  function automatic int ticks_to_close(input bit to_timeout);
    int n;
    n = int'(byte_gap) + 1;
    if (int'(frame_gap) > n) begin
      n = int'(frame_gap);
    end
    if (to_timeout && int'(resp_timeout) > n) begin
      n = int'(resp_timeout);
    end
    return n;
  endfunction

  // Stop offering words, let every expected report arrive, then let the block settle.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [15:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    @(posedge clk);
    case (index)
      CFG_DEVICE_ROLE:     role_master = value[0];
      CFG_OWN_ADDRESS:     own_addr = value[7:0];
      CFG_BYTE_GAP_TICKS:  byte_gap = value;
      CFG_FRAME_GAP_TICKS: frame_gap = value;
      CFG_RESP_TIMEOUT:    resp_timeout = value;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic role, input logic [7:0] own, input logic [15:0] bgap,
                            input logic [15:0] fgap, input logic [15:0] tmo);
    write_register(CFG_DEVICE_ROLE, {15'd0, role});
    write_register(CFG_OWN_ADDRESS, {8'd0, own});
    write_register(CFG_BYTE_GAP_TICKS, bgap);
    write_register(CFG_FRAME_GAP_TICKS, fgap);
    write_register(CFG_RESP_TIMEOUT, tmo);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Slave frames: good, address, CRC and short statuses, gap settings and address extremes.
  task automatic test_slave_frames();
    byte_list_t body;
    // Reset settings: slave at address 1, gaps of 19 and 33 ticks.
    body = '{8'h01, 8'h03, 8'h00, 8'h10};
    send_frame(body, CRC_GOOD);
    send_ticks(ticks_to_close(1'b0));
    wait_drained();
    write_register(CFG_BYTE_GAP_TICKS, 16'd1);
    write_register(CFG_FRAME_GAP_TICKS, 16'd2);
    body = '{8'h02, 8'h03};
    send_frame(body, CRC_GOOD);
    send_ticks(2);
    body = '{8'h01, 8'h06, 8'h44};
    send_frame(body, CRC_BAD);
    send_ticks(2);
    body = '{8'h01, 8'h03, 8'h07};
    send_frame(body, CRC_NONE);
    send_ticks(2);
    // Smallest frame that can pass: address, function and CRC.
    body = '{8'h01, 8'h07};
    send_frame(body, CRC_GOOD);
    send_ticks(2);
    // Ticks and a request while an idle slave listens are ignored.
    send_ticks(2);
    send_request(8'h01, 8'h03);
    wait_drained();
    // The byte gap can be the longer of the two limits.
    write_register(CFG_OWN_ADDRESS, 16'h00FF);
    write_register(CFG_BYTE_GAP_TICKS, 16'd5);
    body = '{8'hFF, 8'hFF, 8'h00};
    send_frame(body, CRC_GOOD);
    send_ticks(ticks_to_close(1'b0));
    wait_drained();
    write_register(CFG_OWN_ADDRESS, 16'h0000);
    write_register(CFG_BYTE_GAP_TICKS, 16'd0);
    write_register(CFG_FRAME_GAP_TICKS, 16'd0);
    body = '{8'h00, 8'h00};
    send_frame(body, CRC_GOOD);
    send_ticks(1);
    wait_drained();
  endtask

  // Master side: response checks, exception replies, timeouts and restarted requests.
  task automatic test_master_frames();
    byte_list_t body;
    set_config(1'b1, 8'h01, 16'd1, 16'd2, 16'd4);
    // An idle master ignores bytes and ticks.
    body = '{8'h11, 8'h03};
    send_frame(body, CRC_GOOD);
    send_ticks(3);
    send_request(8'h11, 8'h03);
    body = '{8'h11, 8'h03, 8'h02, 8'hAB, 8'hCD};
    send_frame(body, CRC_GOOD);
    send_ticks(2);
    send_request(8'h11, 8'h03);
    body = '{8'h11, 8'h83, 8'h02};
    send_frame(body, CRC_GOOD);
    send_ticks(2);
    send_request(8'h11, 8'h03);
    body = '{8'h11, 8'h04, 8'h00};
    send_frame(body, CRC_GOOD);
    send_ticks(2);
    send_request(8'h11, 8'h03);
    body = '{8'h12, 8'h03};
    send_frame(body, CRC_GOOD);
    send_ticks(2);
    send_request(8'h11, 8'h03);
    body = '{8'h11, 8'h03, 8'h00};
    send_frame(body, CRC_BAD);
    send_ticks(2);
    send_request(8'h11, 8'h03);
    body = '{8'h11, 8'h03};
    send_frame(body, CRC_NONE);
    send_ticks(2);
    send_request(8'h11, 8'h03);
    send_ticks(ticks_to_close(1'b1));
    // A new request drops the partial response.
    send_request(8'h11, 8'h03);
    body = '{8'h11, 8'h03};
    send_frame(body, CRC_NONE);
    send_request(8'hFF, 8'hFF);
    body = '{8'hFF, 8'hFF, 8'h01};
    send_frame(body, CRC_GOOD);
    send_ticks(2);
    send_request(8'h00, 8'h00);
    body = '{8'h00, 8'h80, 8'h05};
    send_frame(body, CRC_GOOD);
    send_ticks(2);
    wait_drained();
    write_register(CFG_RESP_TIMEOUT, 16'd0);
    send_request(8'h22, 8'h10);
    send_ticks(ticks_to_close(1'b1));
    wait_drained();
    write_register(CFG_RESP_TIMEOUT, 16'd10);
    send_request(8'h22, 8'h10);
    send_ticks(ticks_to_close(1'b1));
    wait_drained();
  endtask

  // A frame one byte longer than the receive buffer holds: the last byte is dropped.
  task automatic test_buffer_limit();
    byte_list_t body;
    set_config(1'b0, 8'h5A, 16'd0, 16'd1, 16'd0);
    body = '{8'h5A, 8'h10};
    repeat (252) body.push_back(8'($urandom));
    send_frame(body, CRC_GOOD);
    send_ticks(1);
    wait_drained();
  endtask

  // The result side holds off while short frames keep coming, so the input stalls.
  task automatic test_backpressure();
    byte_list_t body;
    set_config(1'b0, 8'h21, 16'd0, 16'd0, 16'd0);
    pressure_hold = 300;
    body = '{8'h21};
    repeat (12) begin
      send_frame(body, CRC_NONE);
      send_ticks(1);
    end
    wait_drained();
  endtask

  // One random request/response or frame, with noise and broken frames mixed in.
  task automatic random_exchange();
    byte_list_t body;
    logic [7:0] target;
    int need;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) send_word(2'($urandom_range(0, 2)), 24'($urandom));
      return;
    end
    if (role_master && $urandom_range(0, 7) != 0) begin
      send_request(pick_byte(), pick_byte());
    end
    if (role_master && model_phase == LINK_WAIT && $urandom_range(0, 5) == 0) begin
      send_ticks(ticks_to_close(1'b1));
      return;
    end
    target = role_master ? req_addr : own_addr;
    body.push_back(($urandom_range(0, 9) != 0) ? target : pick_byte());
    if (role_master) begin
      case ($urandom_range(0, 3))
        0, 1: body.push_back(req_func);
        2: body.push_back(req_func | EXC_FLAG);
        default: body.push_back(pick_byte());
      endcase
    end else begin
      body.push_back(pick_byte());
    end
    repeat ($urandom_range(0, 5)) body.push_back(8'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      need = $urandom_range(1, 3);
      while (body.size() > need) void'(body.pop_back());
      send_frame(body, CRC_NONE);
    end else begin
      send_frame(body, ($urandom_range(0, 6) != 0) ? CRC_GOOD : CRC_BAD);
    end
    need = ticks_to_close(1'b0);
    if ($urandom_range(0, 7) == 0) begin
      // Too little silence: the next bytes run on into the same frame.
      send_ticks($urandom_range(0, need - 1));
    end else begin
      send_ticks(need + $urandom_range(0, 2));
    end
  endtask

  task automatic test_random_traffic();
    int phase_start;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      idle_enabled = (phase != 3);
      set_config(1'($urandom_range(0, 1)), pick_byte(),
                 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 3)),
                 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4)),
                 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12)));
      phase_start = words_sent;
      while (words_sent - phase_start < 25) random_exchange();
    end
  endtask

  // Result side: random hold-offs, a long hold when asked, none in the last part.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_hold > 0) begin
        out_tready = 1'b0;
        for (int held = 1; held < pressure_hold; held++) @(negedge clk);
        pressure_hold = 0;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Compare each delivered report with the oldest one the model predicted.
  always @(posedge clk) begin : check_reports
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected report, status", 0, int'(out_tuser));
      end else begin
        want = pending_frames.pop_front();
        if (out_tuser != want.status) begin
          report_mismatch("frame_status", int'(want.status), int'(out_tuser));
        end
        if (out_tdata[7:0] != want.address) begin
          report_mismatch("frame_address", int'(want.address), int'(out_tdata[7:0]));
        end
        if (out_tdata[15:8] != want.func_code) begin
          report_mismatch("frame_function", int'(want.func_code), int'(out_tdata[15:8]));
        end
        if (out_tdata[23:16] != want.exc_code) begin
          report_mismatch("exception_code", int'(want.exc_code), int'(out_tdata[23:16]));
        end
        if (out_tdata[31:24] != want.length) begin
          report_mismatch("frame_length", int'(want.length), int'(out_tdata[31:24]));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("modbus_rtu_frame_receiver_test NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_BYTE;
    cfg_we = 1'b0;
    cfg_index = CFG_DEVICE_ROLE;
    cfg_wdata = '0;
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_slave_frames();
    test_master_frames();
    test_buffer_limit();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("modbus_rtu_frame_receiver_test OK");
    end else begin
      $display("modbus_rtu_frame_receiver_test NOT OK");
    end
    $finish;
  end

endmodule
